// ===== hw/rtl/masod_pkg.sv =====
// Shared constants and types for the moving-average temperature monitor.
// No dependencies; every other file in hw/rtl except masod_ram refers to this package.
package masod_pkg;

  localparam int DATA_W     = 16;  // temperature sample, 1/256 C per LSB
  localparam int SPIKE_W    = 15;  // spike limit width
  localparam int COLOR_W    = 3;   // LED color code width
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef logic [CFG_IDX_W-1:0] cfg_index_t;
  typedef logic [COLOR_W-1:0]   color_t;

  // Register map
  localparam cfg_index_t CFG_OVERHEAT_LIMIT = 2'd0;
  localparam cfg_index_t CFG_SPIKE_LIMIT    = 2'd1;

  localparam logic signed [DATA_W-1:0] OVERHEAT_RESET = 16'sd9600;  // 37.5 C
  localparam logic [SPIKE_W-1:0]       SPIKE_RESET    = 15'd384;    // 1.5 C

  // LED codes: bit0 red, bit1 green, bit2 blue
  localparam color_t LED_OFF = 3'd0;
  localparam color_t LED_RED = 3'd1;

endpackage

// ===== hw/rtl/masod_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
// Read-first: a read and a write to the same address return the old word.
module masod_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 10,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

// ===== hw/rtl/masod_window.sv =====
// Sample ring and running window sum: ring RAM, fill bits, write slot and sum.
// Depends on masod_pkg and masod_ram.
module masod_window #(
  parameter int WINDOW = 10,
  localparam int SUM_W = masod_pkg::DATA_W + $clog2(WINDOW)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [masod_pkg::DATA_W-1:0] sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [masod_pkg::DATA_W-1:0] out_sample,
  output logic signed [SUM_W-1:0]             out_sum
);

  localparam int SLOT_W = $clog2(WINDOW);

  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] slot_next;
  logic [WINDOW-1:0] filled;

  logic                                v1;
  logic                                old_ok;
  logic signed [masod_pkg::DATA_W-1:0] sample1;
  logic [masod_pkg::DATA_W-1:0]        rd_data;
  logic signed [masod_pkg::DATA_W-1:0] old_word;

  logic                                v2;
  logic signed [masod_pkg::DATA_W-1:0] sample2;
  logic signed [SUM_W-1:0]             window_sum;
  logic signed [SUM_W-1:0]             window_sum_next;

  logic acc;
  logic mv1;
  logic mv2;
  logic rdy2;

  assign rdy2     = !v2 || !out_stall;
  assign mv2      = v2 && !out_stall;
  assign mv1      = v1 && rdy2;
  assign in_stall = v1 && !rdy2;
  assign acc      = in_valid && !in_stall;

  assign slot_next = (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;

  // Read the outgoing entry and write the new sample in the same cycle;
  // the RAM is read-first, so no forwarding is needed.
  masod_ram #(
    .WIDTH(masod_pkg::DATA_W),
    .DEPTH(WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (acc),
    .wr_addr (slot),
    .wr_data (sample),
    .rd_en   (acc),
    .rd_addr (slot),
    .rd_data (rd_data)
  );

  // Entries never written since reset count as zero
  assign old_word        = old_ok ? $signed(rd_data) : '0;
  assign window_sum_next = window_sum - SUM_W'(old_word) + SUM_W'(sample1);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot       <= '0;
      filled     <= '0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      window_sum <= '0;
    end else begin
      if (acc) begin
        slot         <= slot_next;
        filled[slot] <= 1'b1;
      end
      if (acc || mv1) begin
        v1 <= acc;
      end
      if (mv1 || mv2) begin
        v2 <= mv1;
      end
      if (mv1) begin
        window_sum <= window_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      sample1 <= sample;
      old_ok  <= filled[slot];
    end
    if (mv1) begin
      sample2 <= sample1;
    end
  end

  assign out_valid  = v2;
  assign out_sample = sample2;
  assign out_sum    = window_sum;

`ifndef SYNTHESIS
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot <= SLOT_W'(WINDOW - 1))
    else $error("write slot out of window");

  a_sum_hold: assert property (@(posedge clk) disable iff (rst)
    !mv1 |=> $stable(window_sum))
    else $error("window sum changed without an item");
`endif

endmodule

// ===== hw/rtl/masod_eval.sv =====
// Average by constant reciprocal, spike/overheat compares, LED latch, output register.
// Depends on masod_pkg.
module masod_eval #(
  parameter int WINDOW = 10,
  localparam int SUM_W = masod_pkg::DATA_W + $clog2(WINDOW)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [masod_pkg::DATA_W-1:0] sample,
  input  logic signed [SUM_W-1:0]             sum,
  input  logic signed [masod_pkg::DATA_W-1:0] overheat_limit,
  input  logic [masod_pkg::SPIKE_W-1:0]       spike_limit,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [masod_pkg::DATA_W-1:0] average,
  output logic                                spike_seen,
  output logic                                overheat_seen,
  output masod_pkg::color_t                   led_color
);

  // floor(n / WINDOW) == (n * RECIP) >> DIV_SHIFT exactly for n < 2**SUM_W
  localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W   = SUM_W + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam int Q_W       = masod_pkg::DATA_W + 1;
  localparam int DIFF_W    = masod_pkg::DATA_W + 2;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  logic              v3;
  logic              neg3;
  logic [PROD_W-1:0] prod;
  logic signed [masod_pkg::DATA_W-1:0] sample3;
  logic [SUM_W-1:0]  mag;

  logic                                v4;
  logic signed [Q_W-1:0]               avg4;
  logic signed [Q_W-1:0]               avg_next;
  logic [Q_W-1:0]                      quot;
  logic                                hot4;
  logic signed [masod_pkg::DATA_W-1:0] sample4;

  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] lim;
  logic                     spike;

  masod_pkg::color_t color_latch;

  logic rdyo;
  logic rdy4;
  logic rdy3;
  logic acc3;
  logic mv3;
  logic mv4;

  assign rdyo     = !out_valid || !out_stall;
  assign mv4      = v4 && rdyo;
  assign rdy4     = !v4 || rdyo;
  assign mv3      = v3 && rdy4;
  assign rdy3     = !v3 || rdy4;
  assign in_stall = !rdy3;
  assign acc3     = in_valid && rdy3;

  // Divide the magnitude and restore the sign: truncation toward zero
  assign mag      = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign quot     = prod[DIV_SHIFT +: Q_W];
  assign avg_next = neg3 ? -$signed(quot) : $signed(quot);

  assign diff  = DIFF_W'(sample4) - DIFF_W'(avg4);
  assign lim   = $signed({3'b000, spike_limit});
  assign spike = (diff >= lim) || (diff <= -lim);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3          <= 1'b0;
      v4          <= 1'b0;
      out_valid   <= 1'b0;
      color_latch <= masod_pkg::LED_OFF;
    end else begin
      if (acc3 || mv3) begin
        v3 <= acc3;
      end
      if (mv3 || mv4) begin
        v4 <= mv3;
      end
      if (mv4 || rdyo) begin
        out_valid <= mv4;
      end
      if (mv4 && hot4) begin
        color_latch <= masod_pkg::LED_RED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc3) begin
      prod    <= PROD_W'(mag) * PROD_W'(RECIP);
      neg3    <= sum[SUM_W-1];
      sample3 <= sample;
    end
    if (mv3) begin
      avg4    <= avg_next;
      hot4    <= sample3 > overheat_limit;
      sample4 <= sample3;
    end
    if (mv4) begin
      average       <= avg4[masod_pkg::DATA_W-1:0];
      spike_seen    <= spike;
      overheat_seen <= hot4;
      led_color     <= hot4 ? masod_pkg::LED_RED : color_latch;
    end
  end

`ifndef SYNTHESIS
  a_prod_hold: assert property (@(posedge clk) disable iff (rst)
    v3 && !rdy4 |=> v3 && $stable(prod))
    else $error("divider stage lost its item");

  a_hot_red: assert property (@(posedge clk) disable iff (rst)
    out_valid && overheat_seen |-> led_color == masod_pkg::LED_RED)
    else $error("overheat item without red LED");

  a_latch_sticky: assert property (@(posedge clk) disable iff (rst)
    color_latch == masod_pkg::LED_RED |=> color_latch == masod_pkg::LED_RED)
    else $error("overheat latch cleared");
`endif

endmodule

// ===== hw/rtl/moving_average_spike_overheat_detector.sv =====
// Moving-average temperature monitor with spike and overheat flags.
// Depends on masod_pkg, masod_window, masod_eval (and masod_ram below them).
//
// Input channel: temperature_sample with in_valid/in_stall; an item is taken
// at a rising edge with in_valid high and in_stall low. Output channel:
// average, spike_seen, overheat_seen, led_color with out_valid/out_stall.
// Each input item gives exactly one result item, in order.
// Pipeline: ring RAM read, sum update, reciprocal multiply, average/sign,
// compare + output reg. Throughput: one item per cycle unless out_stall
// fills the pipeline; the ring RAM is read and written at the same slot in
// the accept cycle, so back-to-back items never collide.
// Stall: out_stall holds the output register; bubbles inside the pipeline
// still fill, and in_stall rises only once every stage holds an item.
// Reset (rst, synchronous): clears the ring fill bits (unwritten entries
// read as zero), the window sum, the write slot, the LED latch and all
// pipeline valids, and loads the limits with 37.5 C and 1.5 C. There is no
// clearing pass; items are taken right after reset.
// Config: cfg_write with cfg_index/cfg_data; the user must write only while idle, the block does not enforce it.
module moving_average_spike_overheat_detector #(
  parameter int WINDOW = 10
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [masod_pkg::DATA_W-1:0]  temperature_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [masod_pkg::DATA_W-1:0]  average,
  output logic                                 spike_seen,
  output logic                                 overheat_seen,
  output logic [masod_pkg::COLOR_W-1:0]        led_color,
  input  logic                                 cfg_write,
  input  masod_pkg::cfg_index_t                cfg_index,
  input  logic [masod_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SUM_W = masod_pkg::DATA_W + $clog2(WINDOW);

  logic signed [masod_pkg::DATA_W-1:0] overheat_limit;
  logic [masod_pkg::SPIKE_W-1:0]       spike_limit;

  logic                                win_valid;
  logic                                win_stall;
  logic signed [masod_pkg::DATA_W-1:0] win_sample;
  logic signed [SUM_W-1:0]             win_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      overheat_limit <= masod_pkg::OVERHEAT_RESET;
      spike_limit    <= masod_pkg::SPIKE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        masod_pkg::CFG_OVERHEAT_LIMIT: begin
          overheat_limit <= $signed(cfg_data[masod_pkg::DATA_W-1:0]);
        end
        masod_pkg::CFG_SPIKE_LIMIT: begin
          spike_limit <= cfg_data[masod_pkg::SPIKE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  masod_window #(
    .WINDOW(WINDOW)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample     (temperature_sample),
    .out_valid  (win_valid),
    .out_stall  (win_stall),
    .out_sample (win_sample),
    .out_sum    (win_sum)
  );

  masod_eval #(
    .WINDOW(WINDOW)
  ) u_eval (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (win_valid),
    .in_stall       (win_stall),
    .sample         (win_sample),
    .sum            (win_sum),
    .overheat_limit (overheat_limit),
    .spike_limit    (spike_limit),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .average        (average),
    .spike_seen     (spike_seen),
    .overheat_seen  (overheat_seen),
    .led_color      (led_color)
  );

`ifndef SYNTHESIS
  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with an empty output register");
`endif

endmodule

// ===== tb/moving_average_spike_overheat_detector_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the moving-average spike/overheat temperature monitor.
// Needs masod_pkg and the RTL under hw/rtl; no files or arguments are read.
module moving_average_spike_overheat_detector_test;
  import masod_pkg::*;

  localparam int WINDOW       = 10;
  localparam int PIPE_LATENCY = 4;
  localparam int HOLD_CYCLES  = 80;
  localparam int RUN_LIMIT_NS = 2_000_000;

  // indexes past the register map; writes there must be dropped
  localparam cfg_index_t CFG_SPARE_A = 2'd2;
  localparam cfg_index_t CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic signed [DATA_W-1:0] average;
    logic                     spike_seen;
    logic                     overheat_seen;
    color_t                   led_color;
  } reading_t;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_CHECKED, ROW_REGISTER} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    cfg_index_t       index;
    logic [15:0]      value;
    reading_t         reading;
  } row_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] temperature_sample = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] average;
  logic                     spike_seen;
  logic                     overheat_seen;
  color_t                   led_color;
  logic                     cfg_write = 1'b0;
  cfg_index_t               cfg_index = CFG_OVERHEAT_LIMIT;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  // monitor state as the block should hold it
  logic signed [DATA_W-1:0] history [WINDOW];
  int                       history_sum = 0;
  int                       next_slot = 0;
  int                       latest_mean = 0;
  color_t                   led_latch = LED_OFF;
  logic signed [DATA_W-1:0] hot_limit = OVERHEAT_RESET;
  logic [SPIKE_W-1:0]       jump_limit = SPIKE_RESET;

  reading_t pending_readings[$];
  row_t     script[$];

  bit       calm = 1'b0;
  logic [7:0] hold_ticket = '0;
  logic [7:0] hold_seen = '0;
  int       hold_left = 0;

  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int spikes_expected = 0;
  int overheats_expected = 0;
  int reg_writes = 0;
  int backpressure_cycles = 0;

  moving_average_spike_overheat_detector #(.WINDOW(WINDOW)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .temperature_sample(temperature_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .average(average),
    .spike_seen(spike_seen),
    .overheat_seen(overheat_seen),
    .led_color(led_color),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Push one sample through the window and work out what the block reports.
  function automatic reading_t advance_monitor(logic signed [DATA_W-1:0] sample);
    reading_t r;
    int dev;
    history_sum = history_sum - int'(history[next_slot]) + int'(sample);
    history[next_slot] = sample;
    next_slot = (next_slot + 1) % WINDOW;
    latest_mean = history_sum / WINDOW;  // truncates toward zero
    dev = int'(sample) - latest_mean;
    if (dev < 0) dev = -dev;
    r.average = latest_mean[15:0];
    r.spike_seen = (dev >= int'(jump_limit));
    r.overheat_seen = (sample > hot_limit);
    if (r.overheat_seen) led_latch = LED_RED;
    r.led_color = led_latch;
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_sample(int base);
    int roll;
    int v;
    roll = $urandom_range(99);
    if (roll < 55) begin
      v = base + int'($urandom_range(600)) - 300;
    end else if (roll < 80) begin
      v = int'($urandom_range(65535)) - 32768;
    end else if (roll < 88) begin
      v = int'(hot_limit) + int'($urandom_range(2)) - 1;
    end else if (roll < 96) begin
      // land near the spike threshold on either side of the average
      v = int'(jump_limit) + int'($urandom_range(2)) - 1;
      v = $urandom_range(1) ? latest_mean + v : latest_mean - v;
    end else begin
      v = $urandom_range(1) ? 32767 : -32768;
    end
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic void add_sample(logic [15:0] value);
    row_t row;
    row.kind = ROW_SAMPLE;
    row.index = CFG_OVERHEAT_LIMIT;
    row.value = value;
    row.reading = '0;
    script.push_back(row);
  endfunction

  function automatic void add_checked(logic [15:0] value, logic signed [15:0] avg,
                                      logic spike, logic hot, color_t color);
    row_t row;
    row.kind = ROW_CHECKED;
    row.index = CFG_OVERHEAT_LIMIT;
    row.value = value;
    row.reading = {avg, spike, hot, color};
    script.push_back(row);
  endfunction

  function automatic void add_register(cfg_index_t index, logic [15:0] value);
    row_t row;
    row.kind = ROW_REGISTER;
    row.index = index;
    row.value = value;
    row.reading = '0;
    script.push_back(row);
  endfunction

  // Offer one item, wait for the handshake, then maybe idle a few cycles.
  task automatic offer(logic signed [DATA_W-1:0] sample, bit typed, reading_t typed_reading);
    reading_t r;
    in_valid <= 1'b1;
    temperature_sample <= sample;
    do @(posedge clk); while (in_stall);
    r = advance_monitor(sample);
    pending_readings.push_back(typed ? typed_reading : r);
    items_sent++;
    spikes_expected += r.spike_seen;
    overheats_expected += r.overheat_seen;
    while (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stop sending and let every pending result come out.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t index, logic [15:0] value);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (index)
      CFG_OVERHEAT_LIMIT: hot_limit = value;
      CFG_SPIKE_LIMIT:    jump_limit = value[SPIKE_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic run_phase(int count, int base, bit quiet, bit squeeze);
    calm <= quiet;
    for (int n = 0; n < count; n++) begin
      if (squeeze && n == count / 2) hold_ticket <= hold_ticket + 8'd1;
      offer(pick_sample(base), 1'b0, '0);
    end
  endtask

  // Result side: stall at random or on request, check each result taken.
  always @(posedge clk) begin : result_side
    reading_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (in_valid && in_stall) backpressure_cycles++;
      if (out_valid && !out_stall) begin
        if (pending_readings.size() == 0) begin
          $error("result with no item pending: average %0d", average);
          errors++;
        end else begin
          want = pending_readings.pop_front();
          results_checked++;
          if (average !== want.average) begin
            $error("average: expected %0d, got %0d", want.average, average);
            errors++;
          end
          if (spike_seen !== want.spike_seen) begin
            $error("spike_seen: expected %0b, got %0b", want.spike_seen, spike_seen);
            errors++;
          end
          if (overheat_seen !== want.overheat_seen) begin
            $error("overheat_seen: expected %0b, got %0b", want.overheat_seen, overheat_seen);
            errors++;
          end
          if (led_color !== want.led_color) begin
            $error("led_color: expected %0d, got %0d", want.led_color, led_color);
            errors++;
          end
        end
      end
      if (hold_seen != hold_ticket) begin
        hold_seen <= hold_ticket;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 9);
      end
    end
  end

  initial begin : stimulus
    int base;
    foreach (history[i]) history[i] = '0;

    // defaults: overheat above 9600, spike at 384
    add_checked(16'd0, 16'sd0, 1'b0, 1'b0, LED_OFF);
    // spike alone leaves the LED off
    add_checked(16'd4000, 16'sd400, 1'b1, 1'b0, LED_OFF);
    add_checked(16'h8000, -16'sd2876, 1'b1, 1'b0, LED_OFF);
    // exactly at the limit is not overheat
    add_checked(16'd9600, -16'sd1916, 1'b1, 1'b0, LED_OFF);
    add_checked(16'h7FFF, 16'sd1359, 1'b1, 1'b1, LED_RED);
    add_checked(16'd9601, 16'sd2320, 1'b1, 1'b1, LED_RED);
    repeat (9) add_sample(16'h8000);
    // window full of the minimum
    add_checked(16'h8000, -16'sd32768, 1'b0, 1'b0, LED_RED);
    add_sample(16'h7FFF);  // widest deviation
    // bit 15 of the spike value is dropped: limit 0
    add_register(CFG_SPIKE_LIMIT, 16'h8000);
    add_register(CFG_OVERHEAT_LIMIT, 16'h8000);
    add_sample(16'h8000);
    add_sample(16'h8001);
    add_register(CFG_SPARE_A, 16'h0000);
    add_register(CFG_SPARE_B, 16'hFFFF);
    add_sample(16'h0000);
    add_register(CFG_SPIKE_LIMIT, 16'hFFFF);
    add_register(CFG_OVERHEAT_LIMIT, 16'h7FFF);
    add_sample(16'h7FFF);
    add_sample(16'h0000);
    add_sample(16'h8000);
    add_sample(16'h7FFF);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      case (script[i].kind)
        ROW_REGISTER: begin
          settle();
          write_reg(script[i].index, script[i].value);
        end
        ROW_CHECKED: offer(script[i].value, 1'b1, script[i].reading);
        default:     offer(script[i].value, 1'b0, '0);
      endcase
    end

    settle();
    write_reg(CFG_OVERHEAT_LIMIT, OVERHEAT_RESET);
    write_reg(CFG_SPIKE_LIMIT, {1'b0, SPIKE_RESET});
    run_phase(400, 9300, 1'b0, 1'b1);

    settle();
    write_reg(CFG_OVERHEAT_LIMIT, 16'h7FFF);
    write_reg(CFG_SPIKE_LIMIT, 16'h0000);
    run_phase(150, 0, 1'b0, 1'b0);

    settle();
    write_reg(CFG_OVERHEAT_LIMIT, 16'h8000);
    write_reg(CFG_SPIKE_LIMIT, 16'h7FFF);
    run_phase(150, -30000, 1'b0, 1'b1);

    repeat (4) begin
      settle();
      write_reg(CFG_OVERHEAT_LIMIT, 16'($urandom));
      write_reg(CFG_SPIKE_LIMIT, $urandom_range(1) ? 16'($urandom_range(2000)) : 16'($urandom));
      write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, 16'($urandom));
      base = int'(hot_limit) - int'($urandom_range(400));
      run_phase(200, base, 1'b0, 1'b0);
    end

    // back to back on both sides
    settle();
    write_reg(CFG_SPIKE_LIMIT, 16'($urandom_range(1000)));
    run_phase(200, int'(hot_limit) - 150, 1'b1, 1'b0);

    settle();
    repeat (PIPE_LATENCY * 4) @(posedge clk);

    $display("Covered %0d samples and %0d checked results (%0d spikes, %0d overheats).",
             items_sent, results_checked, spikes_expected, overheats_expected);
    $display("Made %0d register writes; input was held off for %0d cycles.",
             reg_writes, backpressure_cycles);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
